>>> rtl/core/keyframe_curve_sampler_core_macros.svh
// ----------------------------------------------------------------------------
// Keyframe curve sampler assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_CURVE_SAMPLER_CORE_MACROS_SVH
`define KEYFRAME_CURVE_SAMPLER_CORE_MACROS_SVH

// same-cycle implication
`define KCS_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KCS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/kcs_pkg.sv
// ----------------------------------------------------------------------------
// kcs_pkg
// Shared types and constants of the keyframe curve sampler.
// ----------------------------------------------------------------------------
package kcs_pkg;

    localparam int MAX_KEYS = 64;
    localparam int ADDR_W   = $clog2(MAX_KEYS);
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;
    localparam int MODE_W   = 3;
    localparam int DATA_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [MODE_W-1:0] MODE_NONE    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_STATIC  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HERMITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_HOLD    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT  = 2'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] out_slope;
        logic [DATA_W-1:0] in_slope;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] key_time;
    } key_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD0, ST_CHK0, ST_RDL, ST_CHKL, ST_SCAN_RD, ST_SCAN_CHK,
        ST_FOUND, ST_DIV, ST_MUL, ST_USE, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        M_NONE, M_V0_ONEMT, M_V1_T, M_T_T, M_T2_T, M_S0_LO, M_S0_HI,
        M_S1_LO, M_S1_HI, M_H00, M_H01, M_H10, M_H11
    } mul_sel_t;

    typedef enum logic [3:0] {
        U_NONE, U_ACC_SET, U_ACC_ADD, U_ACC_SET_SH, U_ACC_ADD_SH,
        U_T2, U_T3, U_TMP, U_M0, U_M1
    } use_sel_t;

    typedef enum logic [2:0] {
        RES_ZERO, RES_STATIC, RES_RD, RES_PREV, RES_ACC_SH, RES_ACC
    } res_sel_t;

    typedef struct packed {
        logic              capture;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              save_prev;
        logic              div_init;
        logic              div_step;
        logic              mul_en;
        mul_sel_t          mul_sel;
        use_sel_t          use_sel;
        logic              load_out;
        res_sel_t          res_sel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic frame_le_rd;
        logic frame_ge_rd;
        logic prev_ge_rd;
        logic out_busy;
    } dp_status_t;

endpackage

>>> rtl/core/kcs_datapath.sv
// ----------------------------------------------------------------------------
// kcs_datapath
// Key table, serial divider, shared multiplier, accumulator and output word.
// ----------------------------------------------------------------------------
module kcs_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  kcs_pkg::ctrl_cmd_t               cmd,
    output kcs_pkg::dp_status_t              status,
    input  logic                             wr_en,
    input  logic [kcs_pkg::ADDR_W-1:0]       wr_addr,
    input  kcs_pkg::key_entry_t              wr_data,
    input  logic [kcs_pkg::DATA_W-1:0]       frame_in,
    input  logic                             cfg_we,
    input  logic [kcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kcs_pkg::DATA_W-1:0]       cfg_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [kcs_pkg::DATA_W-1:0]       sample_value,
    output logic                             saturated
);

    kcs_pkg::key_entry_t key_mem [kcs_pkg::MAX_KEYS];

    kcs_pkg::key_entry_t rd_reg;
    kcs_pkg::key_entry_t prev_reg;
    logic [31:0]         frame_reg;
    logic [31:0]         static_reg;
    logic [32:0]         span_reg;
    logic [33:0]         rem_reg;
    logic [15:0]         t_reg;
    logic                q16_reg;
    logic [15:0]         t2_reg;
    logic [15:0]         t3_reg;
    logic signed [68:0]  p_reg;
    logic signed [68:0]  tmp_reg;
    logic signed [49:0]  m0_reg;
    logic signed [49:0]  m1_reg;
    logic signed [69:0]  acc_reg;
    logic [31:0]         sample_reg;
    logic                sat_reg;
    logic                valid_reg;

    logic [32:0]         d_full;
    logic [32:0]         span_full;
    logic                d_ge_span;
    logic [33:0]         rem2;
    logic                rem_ge;
    logic [15:0]         t_eff;
    logic signed [18:0]  t_s;
    logic signed [18:0]  t2_s;
    logic signed [18:0]  t3_s;
    logic signed [18:0]  h00;
    logic signed [18:0]  h01;
    logic signed [18:0]  h10;
    logic signed [18:0]  h11;
    logic signed [49:0]  mul_a;
    logic signed [18:0]  mul_b;
    logic signed [68:0]  prod;
    logic signed [68:0]  m_sum;
    logic signed [68:0]  m_sh;
    logic signed [68:0]  p_sh;
    logic signed [69:0]  res_val;
    logic                res_hi;
    logic                res_lo;
    logic                res_interp;
    logic [31:0]         res_word;

    function automatic logic signed [49:0] sext50(input logic [31:0] v);
        sext50 = {{18{v[31]}}, v};
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_reg <= key_mem[cmd.rd_addr];
        end
    end

    assign d_full    = {frame_reg[31], frame_reg} - {prev_reg.key_time[31], prev_reg.key_time};
    assign span_full = {rd_reg.key_time[31], rd_reg.key_time}
                     - {prev_reg.key_time[31], prev_reg.key_time};
    assign d_ge_span = d_full >= span_full;
    assign rem2      = {rem_reg[32:0], 1'b0};
    assign rem_ge    = rem2 >= {1'b0, span_reg};

    // a quotient of one means the frame sits on the end key: t clamps
    assign t_eff = q16_reg ? 16'hFFFF : t_reg;
    assign t_s   = {3'b000, t_eff};
    assign t2_s  = {3'b000, t2_reg};
    assign t3_s  = {3'b000, t3_reg};
    assign h00   = (t3_s <<< 1) - (t2_s + (t2_s <<< 1)) + 19'sd65536;
    assign h01   = (t2_s + (t2_s <<< 1)) - (t3_s <<< 1);
    assign h10   = t3_s - (t2_s <<< 1) + t_s;
    assign h11   = t3_s - t2_s;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            kcs_pkg::M_V0_ONEMT: begin mul_a = sext50(prev_reg.value); mul_b = 19'sd65536 - t_s; end
            kcs_pkg::M_V1_T:     begin mul_a = sext50(rd_reg.value);   mul_b = t_s; end
            kcs_pkg::M_T_T:      begin mul_a = {34'd0, t_eff};         mul_b = t_s; end
            kcs_pkg::M_T2_T:     begin mul_a = {34'd0, t2_reg};        mul_b = t_s; end
            kcs_pkg::M_S0_LO:    begin mul_a = sext50(prev_reg.out_slope);
                                       mul_b = {2'b00, span_reg[16:0]}; end
            kcs_pkg::M_S0_HI:    begin mul_a = sext50(prev_reg.out_slope);
                                       mul_b = {3'b000, span_reg[32:17]}; end
            kcs_pkg::M_S1_LO:    begin mul_a = sext50(rd_reg.in_slope);
                                       mul_b = {2'b00, span_reg[16:0]}; end
            kcs_pkg::M_S1_HI:    begin mul_a = sext50(rd_reg.in_slope);
                                       mul_b = {3'b000, span_reg[32:17]}; end
            kcs_pkg::M_H00:      begin mul_a = sext50(prev_reg.value); mul_b = h00; end
            kcs_pkg::M_H01:      begin mul_a = sext50(rd_reg.value);   mul_b = h01; end
            kcs_pkg::M_H10:      begin mul_a = m0_reg;                 mul_b = h10; end
            kcs_pkg::M_H11:      begin mul_a = m1_reg;                 mul_b = h11; end
            default:             begin mul_a = '0;                     mul_b = '0; end
        endcase
    end

    assign prod  = mul_a * mul_b;
    // span is split at bit 17: high partial product weighs 2^17
    assign m_sum = (p_reg <<< 17) + tmp_reg;
    assign m_sh  = m_sum >>> 16;
    assign p_sh  = p_reg >>> 16;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            frame_reg <= frame_in;
        end
        if (cmd.save_prev)
        begin
            prev_reg <= rd_reg;
        end
        if (cmd.div_init)
        begin
            span_reg <= span_full;
            q16_reg  <= d_ge_span;
            rem_reg  <= {1'b0, d_ge_span ? d_full - span_full : d_full};
            t_reg    <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? rem2 - {1'b0, span_reg} : rem2;
            t_reg   <= {t_reg[14:0], rem_ge};
        end
        if (cmd.mul_en)
        begin
            p_reg <= prod;
        end
        case (cmd.use_sel)
            kcs_pkg::U_ACC_SET:    acc_reg <= 70'(p_reg);
            kcs_pkg::U_ACC_ADD:    acc_reg <= acc_reg + 70'(p_reg);
            kcs_pkg::U_ACC_SET_SH: acc_reg <= 70'(p_sh);
            kcs_pkg::U_ACC_ADD_SH: acc_reg <= acc_reg + 70'(p_sh);
            kcs_pkg::U_T2:         t2_reg  <= p_reg[31:16];
            kcs_pkg::U_T3:         t3_reg  <= p_reg[31:16];
            kcs_pkg::U_TMP:        tmp_reg <= p_reg;
            kcs_pkg::U_M0:         m0_reg  <= m_sh[49:0];
            kcs_pkg::U_M1:         m1_reg  <= m_sh[49:0];
            default:               ;
        endcase
    end

    always_comb
    begin
        case (cmd.res_sel)
            kcs_pkg::RES_STATIC: res_val = 70'(signed'(static_reg));
            kcs_pkg::RES_RD:     res_val = 70'(signed'(rd_reg.value));
            kcs_pkg::RES_PREV:   res_val = 70'(signed'(prev_reg.value));
            kcs_pkg::RES_ACC_SH: res_val = acc_reg >>> 16;
            kcs_pkg::RES_ACC:    res_val = acc_reg;
            default:             res_val = '0;
        endcase
    end

    assign res_interp = (cmd.res_sel == kcs_pkg::RES_ACC_SH) || (cmd.res_sel == kcs_pkg::RES_ACC);
    assign res_hi     = res_val > 70'sd2147483647;
    assign res_lo     = res_val < -70'sd2147483648;
    assign res_word   = res_hi ? 32'h7FFF_FFFF : (res_lo ? 32'h8000_0000 : res_val[31:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sample_reg <= res_word;
            sat_reg    <= res_interp && (res_hi || res_lo);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            static_reg <= '0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
            if (cfg_we && (cfg_index == kcs_pkg::CFG_STATIC))
            begin
                static_reg <= cfg_data;
            end
        end
    end

    assign status.frame_le_rd = $signed(frame_reg) <= $signed(rd_reg.key_time);
    assign status.frame_ge_rd = $signed(frame_reg) >= $signed(rd_reg.key_time);
    assign status.prev_ge_rd  = $signed(prev_reg.key_time) >= $signed(rd_reg.key_time);
    assign status.out_busy    = valid_reg && !out_ready;

    assign out_valid    = valid_reg;
    assign sample_value = sample_reg;
    assign saturated    = sat_reg;

endmodule

>>> rtl/core/kcs_ctrl.sv
// ----------------------------------------------------------------------------
// kcs_ctrl
// Query sequencer: key search, divide loop and multiply schedule.
// ----------------------------------------------------------------------------
module kcs_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_kind,
    input  logic [kcs_pkg::IDX_W-1:0]        in_key_index,
    input  logic                             cfg_we,
    input  logic [kcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kcs_pkg::DATA_W-1:0]       cfg_data,
    input  kcs_pkg::dp_status_t              status,
    output kcs_pkg::ctrl_cmd_t               cmd,
    output logic                             wr_en,
    output logic [kcs_pkg::ADDR_W-1:0]       wr_addr
);

    kcs_pkg::state_t                 state_reg, state_next;
    kcs_pkg::res_sel_t               res_reg, res_next;
    logic [kcs_pkg::MODE_W-1:0]      mode_reg;
    logic [kcs_pkg::COUNT_W-1:0]     count_reg;
    logic [kcs_pkg::ADDR_W-1:0]      idx_reg, idx_next;
    logic [3:0]                      div_cnt_reg, div_cnt_next;
    logic [3:0]                      step_reg, step_next;

    logic [kcs_pkg::COUNT_W-1:0]     n_keys;
    logic [kcs_pkg::ADDR_W-1:0]      last_addr;
    logic                            accept;
    logic                            hermite;
    kcs_pkg::mul_sel_t               step_mul;
    kcs_pkg::use_sel_t               step_use;
    logic                            step_last;

    assign n_keys    = (count_reg > kcs_pkg::COUNT_W'(kcs_pkg::MAX_KEYS))
                     ? kcs_pkg::COUNT_W'(kcs_pkg::MAX_KEYS) : count_reg;
    assign last_addr = kcs_pkg::ADDR_W'(n_keys - 1'b1);
    assign accept    = in_valid && in_ready;
    assign hermite   = mode_reg == kcs_pkg::MODE_HERMITE;

    assign wr_en   = accept && (in_kind == kcs_pkg::KIND_WRITE)
                   && ({1'b0, in_key_index} < (kcs_pkg::IDX_W+1)'(kcs_pkg::MAX_KEYS));
    assign wr_addr = in_key_index[kcs_pkg::ADDR_W-1:0];

    // multiply schedule: linear is two steps, hermite ten
    always_comb
    begin
        step_mul  = kcs_pkg::M_NONE;
        step_use  = kcs_pkg::U_NONE;
        step_last = 1'b0;
        if (!hermite)
        begin
            case (step_reg)
                4'd0:    begin step_mul = kcs_pkg::M_V0_ONEMT; step_use = kcs_pkg::U_ACC_SET; end
                default: begin step_mul = kcs_pkg::M_V1_T; step_use = kcs_pkg::U_ACC_ADD;
                               step_last = 1'b1; end
            endcase
        end
        else
        begin
            case (step_reg)
                4'd0:    begin step_mul = kcs_pkg::M_T_T;   step_use = kcs_pkg::U_T2; end
                4'd1:    begin step_mul = kcs_pkg::M_T2_T;  step_use = kcs_pkg::U_T3; end
                4'd2:    begin step_mul = kcs_pkg::M_S0_LO; step_use = kcs_pkg::U_TMP; end
                4'd3:    begin step_mul = kcs_pkg::M_S0_HI; step_use = kcs_pkg::U_M0; end
                4'd4:    begin step_mul = kcs_pkg::M_S1_LO; step_use = kcs_pkg::U_TMP; end
                4'd5:    begin step_mul = kcs_pkg::M_S1_HI; step_use = kcs_pkg::U_M1; end
                4'd6:    begin step_mul = kcs_pkg::M_H00;   step_use = kcs_pkg::U_ACC_SET_SH; end
                4'd7:    begin step_mul = kcs_pkg::M_H01;   step_use = kcs_pkg::U_ACC_ADD_SH; end
                4'd8:    begin step_mul = kcs_pkg::M_H10;   step_use = kcs_pkg::U_ACC_ADD_SH; end
                default: begin step_mul = kcs_pkg::M_H11;   step_use = kcs_pkg::U_ACC_ADD_SH;
                               step_last = 1'b1; end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= kcs_pkg::ST_IDLE;
            res_reg     <= kcs_pkg::RES_ZERO;
            mode_reg    <= kcs_pkg::MODE_NONE;
            count_reg   <= '0;
            idx_reg     <= '0;
            div_cnt_reg <= '0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            res_reg     <= res_next;
            idx_reg     <= idx_next;
            div_cnt_reg <= div_cnt_next;
            step_reg    <= step_next;
            if (cfg_we && (cfg_index == kcs_pkg::CFG_MODE))
            begin
                mode_reg <= cfg_data[kcs_pkg::MODE_W-1:0];
            end
            if (cfg_we && (cfg_index == kcs_pkg::CFG_COUNT))
            begin
                count_reg <= cfg_data[kcs_pkg::COUNT_W-1:0];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        res_next     = res_reg;
        idx_next     = idx_reg;
        div_cnt_next = div_cnt_reg;
        step_next    = step_reg;
        in_ready     = 1'b0;
        cmd          = '0;
        cmd.mul_sel  = kcs_pkg::M_NONE;
        cmd.use_sel  = kcs_pkg::U_NONE;
        cmd.res_sel  = res_reg;
        case (state_reg)
            kcs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (accept && (in_kind == kcs_pkg::KIND_QUERY))
                begin
                    cmd.capture = 1'b1;
                    state_next  = kcs_pkg::ST_DONE;
                    if (mode_reg == kcs_pkg::MODE_STATIC)
                    begin
                        res_next = kcs_pkg::RES_STATIC;
                    end
                    else if ((mode_reg == kcs_pkg::MODE_NONE) || (mode_reg > kcs_pkg::MODE_HOLD)
                             || (n_keys == '0))
                    begin
                        res_next = kcs_pkg::RES_ZERO;
                    end
                    else
                    begin
                        state_next = kcs_pkg::ST_RD0;
                    end
                end
            end
            kcs_pkg::ST_RD0:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = '0;
                state_next  = kcs_pkg::ST_CHK0;
            end
            kcs_pkg::ST_CHK0:
            begin
                if ((n_keys == kcs_pkg::COUNT_W'(1)) || status.frame_le_rd)
                begin
                    res_next   = kcs_pkg::RES_RD;
                    state_next = kcs_pkg::ST_DONE;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    state_next    = kcs_pkg::ST_RDL;
                end
            end
            kcs_pkg::ST_RDL:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = last_addr;
                state_next  = kcs_pkg::ST_CHKL;
            end
            kcs_pkg::ST_CHKL:
            begin
                if (status.frame_ge_rd)
                begin
                    res_next   = kcs_pkg::RES_RD;
                    state_next = kcs_pkg::ST_DONE;
                end
                else
                begin
                    idx_next   = kcs_pkg::ADDR_W'(1);
                    state_next = kcs_pkg::ST_SCAN_RD;
                end
            end
            kcs_pkg::ST_SCAN_RD:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = idx_reg;
                state_next  = kcs_pkg::ST_SCAN_CHK;
            end
            kcs_pkg::ST_SCAN_CHK:
            begin
                // the last key is past the frame, so the scan always stops in range
                if (status.frame_le_rd)
                begin
                    state_next = kcs_pkg::ST_FOUND;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    idx_next      = idx_reg + 1'b1;
                    state_next    = kcs_pkg::ST_SCAN_RD;
                end
            end
            kcs_pkg::ST_FOUND:
            begin
                if (status.prev_ge_rd)
                begin
                    res_next   = kcs_pkg::RES_PREV;
                    state_next = kcs_pkg::ST_DONE;
                end
                else if (mode_reg == kcs_pkg::MODE_HOLD)
                begin
                    res_next   = status.frame_ge_rd ? kcs_pkg::RES_RD : kcs_pkg::RES_PREV;
                    state_next = kcs_pkg::ST_DONE;
                end
                else
                begin
                    cmd.div_init = 1'b1;
                    div_cnt_next = '0;
                    state_next   = kcs_pkg::ST_DIV;
                end
            end
            kcs_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == 4'd15)
                begin
                    step_next  = '0;
                    state_next = kcs_pkg::ST_MUL;
                end
            end
            kcs_pkg::ST_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = step_mul;
                state_next  = kcs_pkg::ST_USE;
            end
            kcs_pkg::ST_USE:
            begin
                cmd.use_sel = step_use;
                step_next   = step_reg + 1'b1;
                if (step_last)
                begin
                    res_next   = hermite ? kcs_pkg::RES_ACC : kcs_pkg::RES_ACC_SH;
                    state_next = kcs_pkg::ST_DONE;
                end
                else
                begin
                    state_next = kcs_pkg::ST_MUL;
                end
            end
            kcs_pkg::ST_DONE:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = kcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kcs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/keyframe_curve_sampler_core.sv
// ----------------------------------------------------------------------------
// keyframe_curve_sampler_core
// Keyframe table with linear, Hermite and hold sampling in Q16.16.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis; tuser[0] selects a key write (0) or a query (1).
// A key write stores one table entry in its accept cycle and returns nothing.
// A query returns one word on m_axis: the sample and a saturation flag.
// Mode, static value and key count are set through cfg_we/cfg_index/cfg_data
// while no query is in flight: a rule for the user, not enforced by the block.
// A query with static, none, or an empty table reads no key. Otherwise the
// single table read port reads the first key, then the last, then scans the
// keys in order; a frame at or before the first key or at or after the last
// ends there, as do hold mode and equal key times after the scan. Else the
// radix-2 divider forms t and the shared multiplier runs its steps (2 steps
// linear, 10 Hermite).
// One query is worked at a time; s_axis_tready is low until its result word
// is loaded into the output register, which holds while m_axis_tready is low.
// Reset clears mode, static value, key count and the output valid; the key
// table is not cleared and must be written before it is sampled.
// ----------------------------------------------------------------------------
module keyframe_curve_sampler_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // key_index[5:0], key_time[37:6], key_value[69:38], key_in_slope[101:70],
    // key_out_slope[133:102], query_frame[165:134], zero pad [167:166]
    input  logic [167:0]                     s_axis_tdata,
    // kind[0]
    input  logic [0:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // sample_value[31:0]
    output logic [31:0]                      m_axis_tdata,
    // saturated[0]
    output logic [0:0]                       m_axis_tuser,
    input  logic                             cfg_we,
    input  logic [kcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kcs_pkg::DATA_W-1:0]       cfg_data
);

    kcs_pkg::ctrl_cmd_t    cmd;
    kcs_pkg::dp_status_t   status;
    kcs_pkg::key_entry_t   wr_data;
    logic                  wr_en;
    logic [kcs_pkg::ADDR_W-1:0] wr_addr;

    assign wr_data.key_time  = s_axis_tdata[37:6];
    assign wr_data.value     = s_axis_tdata[69:38];
    assign wr_data.in_slope  = s_axis_tdata[101:70];
    assign wr_data.out_slope = s_axis_tdata[133:102];

    kcs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_kind      (s_axis_tuser[0]),
        .in_key_index (s_axis_tdata[5:0]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .cmd          (cmd),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr)
    );

    kcs_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .frame_in     (s_axis_tdata[165:134]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .sample_value (m_axis_tdata),
        .saturated    (m_axis_tuser[0])
    );

endmodule

>>> rtl/core/kcs_checker.sv
// ----------------------------------------------------------------------------
// kcs_checker
// Port-level checks of the keyframe curve sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "keyframe_curve_sampler_core_macros.svh"

module kcs_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [167:0]                     s_axis_tdata,
    input  logic [0:0]                       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [31:0]                      m_axis_tdata,
    input  logic [0:0]                       m_axis_tuser,
    input  logic                             cfg_we,
    input  logic [kcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [kcs_pkg::DATA_W-1:0]       cfg_data
);

    logic s_acc;
    logic unused_ok;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign unused_ok = ^{s_axis_tdata, cfg_we, cfg_index, cfg_data};

    `KCS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled output word changed")

    `KCS_ASSERT_IMPL(a_sat_clip, m_axis_tvalid && m_axis_tuser[0],
        (m_axis_tdata == 32'h7FFF_FFFF) || (m_axis_tdata == 32'h8000_0000),
        "saturated flag without clipped value")

    `KCS_ASSERT_NEXT(a_write_silent,
        s_acc && (s_axis_tuser[0] == kcs_pkg::KIND_WRITE) && !m_axis_tvalid,
        !m_axis_tvalid, "key write produced a result word")

    `KCS_ASSERT_NEXT(a_query_busy, s_acc && (s_axis_tuser[0] == kcs_pkg::KIND_QUERY),
        !s_axis_tready, "input taken while a query is in flight")

endmodule

bind keyframe_curve_sampler_core kcs_checker u_kcs_checker (.*);
